>>> hdl/ttc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttc_pkg;

   // field widths
   localparam int SecWidth  = 7;
   localparam int TempWidth = 10;
   localparam int AdcWidth  = 10;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 10;

   // register reset values
   localparam logic [SecWidth-1:0]  ShortSecondsReset = 7'd10;
   localparam logic [SecWidth-1:0]  LongSecondsReset  = 7'd60;
   localparam logic [TempWidth-1:0] HeatOnBelowReset  = 10'd600;
   localparam logic [TempWidth-1:0] HeatOffAboveReset = 10'd800;
   localparam logic [TempWidth-1:0] RefreshMarginReset = 10'd2;

   // register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SHORT_SECONDS  = 3'd0,
      CSR_LONG_SECONDS   = 3'd1,
      CSR_HEAT_ON_BELOW  = 3'd2,
      CSR_HEAT_OFF_ABOVE = 3'd3,
      CSR_REFRESH_MARGIN = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                mode_button;
      logic                start_button;
      logic [AdcWidth-1:0] adc_sample;
      logic                quarter_tick;
   } req_type;

   typedef struct packed {
      logic                 heater_on;
      logic                 running_now;
      logic                 long_mode;
      logic [SecWidth-1:0]  seconds_left;
      logic [TempWidth-1:0] temp_tenths;
      logic                 temp_refresh;
      logic                 time_refresh;
      logic                 mode_refresh;
   } rsp_type;

   // sample*1000/1023 rounded down: reciprocal estimate plus one correction step
   function automatic logic [TempWidth-1:0] tenths_of(input logic [AdcWidth-1:0] sample);
      logic [19:0] scaled;
      logic [19:0] est_sum;
      logic [9:0]  q_est;
      logic [19:0] back;
      logic [19:0] rem;
      scaled  = {sample, 10'b0} - {6'b0, sample, 4'b0} - {7'b0, sample, 3'b0};
      est_sum = scaled + {10'b0, scaled[19:10]};
      q_est   = est_sum[19:10];
      back    = {q_est, 10'b0} - {10'b0, q_est};
      rem     = scaled - back;
      if (rem >= 20'd1023) begin
         tenths_of = q_est + 10'd1;
      end else begin
         tenths_of = q_est;
      end
   endfunction

endpackage

`default_nettype wire

>>> hdl/timed_thermostat_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel    | direction | handshake              | payload
// -----------+-----------+------------------------+------------------------------
// req        | in        | req_valid / req_stall  | req_payload (poll of buttons,
//            |           |                        | converter sample, quarter tick)
// rsp        | out       | rsp_valid / rsp_stall  | rsp_payload (heater, timer,
//            |           |                        | temperature, refresh flags)
// csr        | in        | csr_write_en           | csr_index, csr_wdata
//
// One request a cycle while req_stall is low. A taken request passes through the input
// register, which holds the scaled temperature, and then the result register, which holds
// the controller state update and offers the result. Reset is synchronous
// and restores the register defaults and the idle short mode. A stalled result holds
// the result register and, once the input register is also full, raises req_stall.

module timed_thermostat_controller_unit
   import ttc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_type                  req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_payload,
   input  wire logic                     csr_write_en,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   // configuration registers
   logic [SecWidth-1:0]  short_seconds_ff;
   logic [SecWidth-1:0]  long_seconds_ff;
   logic [TempWidth-1:0] heat_on_below_ff;
   logic [TempWidth-1:0] heat_off_above_ff;
   logic [TempWidth-1:0] refresh_margin_ff;

   // pipeline registers
   logic                 in_valid_ff;
   req_type              in_req_ff;
   logic [TempWidth-1:0] in_temp_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   rsp_type              out_rsp_ff;
   rsp_type              out_rsp_in;

   // controller state
   logic                 mode_ff, mode_in;
   logic                 run_ff, run_in;
   logic [SecWidth-1:0]  remaining_ff, remaining_in;
   logic [1:0]           quarter_ff, quarter_in;
   logic                 mode_pressed_ff, mode_pressed_in;
   logic                 start_pressed_ff, start_pressed_in;
   logic                 heater_ff, heater_in;
   logic [TempWidth-1:0] shown_temp_ff, shown_temp_in;
   logic                 shown_temp_valid_ff, shown_temp_valid_in;
   logic [SecWidth-1:0]  shown_time_ff, shown_time_in;
   logic                 shown_time_valid_ff, shown_time_valid_in;
   logic                 shown_mode_ff, shown_mode_in;
   logic                 shown_mode_valid_ff, shown_mode_valid_in;

   logic out_free;
   logic fire;

   // handshake: the result register frees when empty or when its result is taken
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign req_stall   = in_valid_ff && !out_free;
   assign fire        = in_valid_ff && out_free;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         short_seconds_ff  <= ShortSecondsReset;
         long_seconds_ff   <= LongSecondsReset;
         heat_on_below_ff  <= HeatOnBelowReset;
         heat_off_above_ff <= HeatOffAboveReset;
         refresh_margin_ff <= RefreshMarginReset;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SHORT_SECONDS:  short_seconds_ff  <= csr_wdata[SecWidth-1:0];
            CSR_LONG_SECONDS:   long_seconds_ff   <= csr_wdata[SecWidth-1:0];
            CSR_HEAT_ON_BELOW:  heat_on_below_ff  <= csr_wdata[TempWidth-1:0];
            CSR_HEAT_OFF_ABOVE: heat_off_above_ff <= csr_wdata[TempWidth-1:0];
            CSR_REFRESH_MARGIN: refresh_margin_ff <= csr_wdata[TempWidth-1:0];
            default: ;
         endcase
      end
   end

   // input register with temperature scaling
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_req_ff  <= req_payload;
         in_temp_ff <= tenths_of(req_payload.adc_sample);
      end
   end

   // controller update for one request, in poll order
   always_comb begin
      logic                   tick_step;
      logic [1:0]             quarter_inc;
      logic                   start_edge;
      logic                   t_ref;
      logic                   tm_ref;
      logic                   m_ref;
      logic [TempWidth:0]     temp_hi;
      logic [TempWidth:0]     shown_hi;
      mode_in             = mode_ff;
      run_in              = run_ff;
      remaining_in        = remaining_ff;
      quarter_in          = quarter_ff;
      heater_in           = heater_ff;
      shown_temp_in       = shown_temp_ff;
      shown_temp_valid_in = shown_temp_valid_ff;
      shown_time_in       = shown_time_ff;
      shown_time_valid_in = shown_time_valid_ff;
      shown_mode_in       = shown_mode_ff;
      shown_mode_valid_in = shown_mode_valid_ff;
      t_ref               = 1'b0;
      tm_ref              = 1'b0;
      m_ref               = 1'b0;
      mode_pressed_in     = in_req_ff.mode_button;
      start_pressed_in    = in_req_ff.start_button;

      // quarter ticks count down the run
      tick_step   = run_ff && in_req_ff.quarter_tick;
      quarter_inc = quarter_ff + 2'd1;
      if (tick_step) begin
         quarter_in = quarter_inc;
         if (quarter_inc == 2'd0 && remaining_ff != '0) begin
            remaining_in = remaining_ff - SecWidth'(1);
         end
      end

      // mode toggle while idle
      if (in_req_ff.mode_button && !mode_pressed_ff && !run_ff) begin
         mode_in      = !mode_ff;
         remaining_in = !mode_ff ? long_seconds_ff : short_seconds_ff;
      end

      // start of a run
      start_edge = in_req_ff.start_button && !start_pressed_ff && !run_ff;
      if (start_edge) begin
         run_in              = 1'b1;
         shown_time_valid_in = 1'b0;
         shown_temp_valid_in = 1'b0;
         remaining_in        = mode_in ? long_seconds_ff : short_seconds_ff;
         quarter_in          = 2'd0;
      end

      // temperature line redraw
      temp_hi  = {1'b0, in_temp_ff};
      shown_hi = {1'b0, shown_temp_ff};
      if (!shown_temp_valid_in ||
          temp_hi > shown_hi + {1'b0, refresh_margin_ff} ||
          shown_hi > temp_hi + {1'b0, refresh_margin_ff}) begin
         t_ref               = 1'b1;
         shown_temp_in       = in_temp_ff;
         shown_temp_valid_in = 1'b1;
      end

      if (!run_in) begin
         // idle: heater off, mode line redraw
         heater_in = 1'b0;
         if (!shown_mode_valid_ff || shown_mode_ff != mode_in) begin
            m_ref               = 1'b1;
            shown_mode_in       = mode_in;
            shown_mode_valid_in = 1'b1;
         end
      end else begin
         // running: two-limit heater, time line redraw, end of run
         if (in_temp_ff < heat_on_below_ff) begin
            heater_in = 1'b1;
         end else if (in_temp_ff > heat_off_above_ff) begin
            heater_in = 1'b0;
         end
         if (!shown_time_valid_in || shown_time_ff != remaining_in) begin
            tm_ref              = 1'b1;
            shown_time_in       = remaining_in;
            shown_time_valid_in = 1'b1;
         end
         if (remaining_in == '0) begin
            run_in              = 1'b0;
            shown_mode_valid_in = 1'b0;
            shown_temp_valid_in = 1'b0;
            remaining_in        = mode_in ? long_seconds_ff : short_seconds_ff;
         end
      end

      out_rsp_in.heater_on    = heater_in;
      out_rsp_in.running_now  = run_in;
      out_rsp_in.long_mode    = mode_in;
      out_rsp_in.seconds_left = remaining_in;
      out_rsp_in.temp_tenths  = in_temp_ff;
      out_rsp_in.temp_refresh = t_ref;
      out_rsp_in.time_refresh = tm_ref;
      out_rsp_in.mode_refresh = m_ref;

      // result valid: set on update, cleared once taken
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff        <= 1'b0;
         mode_ff             <= 1'b0;
         run_ff              <= 1'b0;
         remaining_ff        <= ShortSecondsReset;
         quarter_ff          <= 2'd0;
         mode_pressed_ff     <= 1'b0;
         start_pressed_ff    <= 1'b0;
         heater_ff           <= 1'b0;
         shown_temp_ff       <= '0;
         shown_temp_valid_ff <= 1'b0;
         shown_time_ff       <= '0;
         shown_time_valid_ff <= 1'b0;
         shown_mode_ff       <= 1'b0;
         shown_mode_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            mode_ff             <= mode_in;
            run_ff              <= run_in;
            remaining_ff        <= remaining_in;
            quarter_ff          <= quarter_in;
            mode_pressed_ff     <= mode_pressed_in;
            start_pressed_ff    <= start_pressed_in;
            heater_ff           <= heater_in;
            shown_temp_ff       <= shown_temp_in;
            shown_temp_valid_ff <= shown_temp_valid_in;
            shown_time_ff       <= shown_time_in;
            shown_time_valid_ff <= shown_time_valid_in;
            shown_mode_ff       <= shown_mode_in;
            shown_mode_valid_ff <= shown_mode_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

endmodule

`default_nettype wire

>>> tb/timed_thermostat_controller_unit_tb.sv
`timescale 1ns / 1ps

module timed_thermostat_controller_unit_tb;
   import ttc_pkg::*;

   // predicted controller state and queue of expected status words
   class thermostat_scoreboard;
      logic [SecWidth-1:0]  short_seconds;
      logic [SecWidth-1:0]  long_seconds;
      logic [TempWidth-1:0] heat_on_below;
      logic [TempWidth-1:0] heat_off_above;
      logic [TempWidth-1:0] refresh_margin;
      bit                   long_sel;
      bit                   running;
      bit                   heater;
      bit                   mode_held;
      bit                   start_held;
      logic [SecWidth-1:0]  secs_left;
      logic [1:0]           quarters;
      int                   shown_temp;
      logic [SecWidth-1:0]  shown_time;
      bit                   shown_mode;
      bit                   temp_shown;
      bit                   time_shown;
      bit                   mode_shown;
      rsp_type              predicted_status[$];
      int                   mismatches;

      function new();
         short_seconds  = ShortSecondsReset;
         long_seconds   = LongSecondsReset;
         heat_on_below  = HeatOnBelowReset;
         heat_off_above = HeatOffAboveReset;
         refresh_margin = RefreshMarginReset;
         long_sel   = 1'b0;
         running    = 1'b0;
         heater     = 1'b0;
         mode_held  = 1'b0;
         start_held = 1'b0;
         secs_left  = ShortSecondsReset;
         quarters   = 2'd0;
         shown_temp = 0;
         shown_time = '0;
         shown_mode = 1'b0;
         temp_shown = 1'b0;
         time_shown = 1'b0;
         mode_shown = 1'b0;
         mismatches = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CsrDataWidth-1:0] value);
         case (idx)
            CSR_SHORT_SECONDS:  short_seconds  = value[SecWidth-1:0];
            CSR_LONG_SECONDS:   long_seconds   = value[SecWidth-1:0];
            CSR_HEAT_ON_BELOW:  heat_on_below  = value[TempWidth-1:0];
            CSR_HEAT_OFF_ABOVE: heat_off_above = value[TempWidth-1:0];
            CSR_REFRESH_MARGIN: refresh_margin = value[TempWidth-1:0];
            default: ;
         endcase
      endfunction

      function logic [SecWidth-1:0] run_length();
         return long_sel ? long_seconds : short_seconds;
      endfunction

      function int pending();
         return predicted_status.size();
      endfunction

      function void predict_poll(req_type poll);
         rsp_type want;
         int      temp;
         int      margin;
         bit      temp_redraw;
         bit      time_redraw;
         bit      mode_redraw;
         temp_redraw = 1'b0;
         time_redraw = 1'b0;
         mode_redraw = 1'b0;
         margin = int'(refresh_margin);

         // four quarter ticks of a run make one second, stopping at zero
         if (running && poll.quarter_tick) begin
            quarters = quarters + 2'd1;
            if (quarters == 2'd0 && secs_left != '0) begin
               secs_left = secs_left - 1'b1;
            end
         end

         // mode press toggles and reloads only while idle
         if (poll.mode_button && !mode_held) begin
            mode_held = 1'b1;
            if (!running) begin
               long_sel  = ~long_sel;
               secs_left = run_length();
            end
         end
         if (!poll.mode_button) begin
            mode_held = 1'b0;
         end

         // start press begins a run only while idle
         if (poll.start_button && !start_held) begin
            start_held = 1'b1;
            if (!running) begin
               running    = 1'b1;
               time_shown = 1'b0;
               temp_shown = 1'b0;
               secs_left  = run_length();
               quarters   = 2'd0;
            end
         end
         if (!poll.start_button) begin
            start_held = 1'b0;
         end

         // temperature line redraw outside the margin band
         temp = int'(poll.adc_sample) * 1000 / 1023;
         if (!temp_shown || temp > shown_temp + margin || shown_temp > temp + margin) begin
            temp_redraw = 1'b1;
            shown_temp  = temp;
            temp_shown  = 1'b1;
         end

         if (!running) begin
            // heater forced off, mode line redrawn on change
            heater = 1'b0;
            if (!mode_shown || shown_mode != long_sel) begin
               mode_redraw = 1'b1;
               shown_mode  = long_sel;
               mode_shown  = 1'b1;
            end
         end else begin
            // two-limit control, switching on wins
            if (temp < int'(heat_on_below)) begin
               heater = 1'b1;
            end else if (temp > int'(heat_off_above)) begin
               heater = 1'b0;
            end
            if (!time_shown || shown_time != secs_left) begin
               time_redraw = 1'b1;
               shown_time  = secs_left;
               time_shown  = 1'b1;
            end
            // run over: reload and force redraws
            if (secs_left == '0) begin
               running    = 1'b0;
               mode_shown = 1'b0;
               temp_shown = 1'b0;
               secs_left  = run_length();
            end
         end

         want.heater_on    = heater;
         want.running_now  = running;
         want.long_mode    = long_sel;
         want.seconds_left = secs_left;
         want.temp_tenths  = TempWidth'(temp);
         want.temp_refresh = temp_redraw;
         want.time_refresh = time_redraw;
         want.mode_refresh = mode_redraw;
         predicted_status.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_status(rsp_type got);
         rsp_type want;
         if (predicted_status.size() == 0) begin
            $error("status %h with no request outstanding", got);
            mismatches++;
            return;
         end
         want = predicted_status.pop_front();
         compare_field("heater_on", 32'(want.heater_on), 32'(got.heater_on));
         compare_field("running_now", 32'(want.running_now), 32'(got.running_now));
         compare_field("long_mode", 32'(want.long_mode), 32'(got.long_mode));
         compare_field("seconds_left", 32'(want.seconds_left), 32'(got.seconds_left));
         compare_field("temp_tenths", 32'(want.temp_tenths), 32'(got.temp_tenths));
         compare_field("temp_refresh", 32'(want.temp_refresh), 32'(got.temp_refresh));
         compare_field("time_refresh", 32'(want.time_refresh), 32'(got.time_refresh));
         compare_field("mode_refresh", 32'(want.mode_refresh), 32'(got.mode_refresh));
      endfunction
   endclass

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_HOLD
   } stall_kind_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_type                  rsp_payload;
   logic                     csr_write_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   thermostat_scoreboard board = new();

   // button and sensor levels behind the well-formed polls
   bit             mode_level;
   bit             start_level;
   int             adc_level;
   stall_kind_type stall_kind;
   int             stall_left;

   timed_thermostat_controller_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // handshake monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.predict_poll(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_status(rsp_payload);
         end
      end
   end

   // result side back-pressure in stretches of differing density
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind = stall_kind_type'($urandom_range(0, 3));
         stall_left = (stall_kind == STALL_HOLD) ? $urandom_range(1, 8) : $urandom_range(5, 40);
      end
      stall_left--;
      case (stall_kind)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= 1'b1;
      endcase
   end

   function automatic req_type poll(bit mode_btn, bit start_btn, int adc, bit tick);
      req_type p;
      p.mode_button  = mode_btn;
      p.start_button = start_btn;
      p.adc_sample   = AdcWidth'(adc);
      p.quarter_tick = tick;
      return p;
   endfunction

   // mostly slow button edges and a drifting sample, some pure noise
   function automatic req_type next_poll();
      req_type p;
      if ($urandom_range(0, 4) == 0) begin
         p.mode_button  = 1'($urandom_range(0, 1));
         p.start_button = 1'($urandom_range(0, 1));
         p.adc_sample   = AdcWidth'($urandom_range(0, 1023));
         p.quarter_tick = 1'($urandom_range(0, 1));
      end else begin
         if ($urandom_range(0, 9) == 0) begin
            mode_level = ~mode_level;
         end
         if ($urandom_range(0, 7) == 0) begin
            start_level = ~start_level;
         end
         if ($urandom_range(0, 5) == 0) begin
            adc_level = $urandom_range(0, 1023);
         end else begin
            adc_level = adc_level + int'($urandom_range(0, 10)) - 5;
            if (adc_level < 0) adc_level = 0;
            if (adc_level > 1023) adc_level = 1023;
         end
         p = poll(mode_level, start_level, adc_level, $urandom_range(0, 2) != 0);
      end
      return p;
   endfunction

   function automatic logic [SecWidth-1:0] pick_seconds();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return ($urandom_range(0, 1) != 0) ? 7'd127 : 7'd99;
      if (r == 1) return 7'd0;
      return SecWidth'($urandom_range(1, 6));
   endfunction

   function automatic logic [TempWidth-1:0] pick_limit();
      int r;
      r = $urandom_range(0, 5);
      if (r == 0) return 10'd0;
      if (r == 1) return 10'd1023;
      return TempWidth'($urandom_range(0, 1023));
   endfunction

   // hold the request until taken
   task automatic send_request(req_type p);
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender(int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for every expected status, then let the pipeline settle
   task automatic finish_phase();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic apply_settings(logic [SecWidth-1:0] short_len, logic [SecWidth-1:0] long_len,
                                 logic [TempWidth-1:0] on_below, logic [TempWidth-1:0] off_above,
                                 logic [TempWidth-1:0] margin);
      logic [CsrDataWidth-1:0] values [5];
      values[0] = CsrDataWidth'(short_len);
      values[1] = CsrDataWidth'(long_len);
      values[2] = on_below;
      values[3] = off_above;
      values[4] = margin;
      for (int i = 0; i < 5; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= csr_index_type'(i);
         csr_wdata    <= values[i];
         board.write_register(csr_index_type'(i), values[i]);
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int n;
      int burst;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_stall    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      reset        = 1'b1;
      mode_level   = 1'b0;
      start_level  = 1'b0;
      adc_level    = 512;
      stall_kind   = STALL_NONE;
      stall_left   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default registers: sample extremes, idle tick, mode toggling
      send_request(poll(0, 0, 0, 0));
      pause_sender($urandom_range(0, 2));
      send_request(poll(0, 0, 1023, 1));
      pause_sender($urandom_range(0, 2));
      send_request(poll(0, 0, 1022, 0));
      send_request(poll(1, 0, 512, 0));
      send_request(poll(1, 0, 512, 1));
      pause_sender($urandom_range(0, 2));
      send_request(poll(0, 0, 512, 0));
      send_request(poll(1, 0, 512, 0));
      send_request(poll(0, 0, 300, 1));
      send_request(poll(0, 0, 1, 0));
      finish_phase();

      // zero short run, two second long run, switch-on limit above every temperature, switch-off limit zero
      apply_settings(7'd0, 7'd2, 10'd1023, 10'd0, 10'd0);
      send_request(poll(0, 1, 100, 1));
      send_request(poll(0, 0, 100, 0));
      pause_sender($urandom_range(0, 2));
      send_request(poll(1, 0, 101, 0));
      send_request(poll(0, 1, 101, 0));
      send_request(poll(1, 1, 1023, 1));
      pause_sender($urandom_range(0, 2));
      send_request(poll(0, 0, 1023, 1));
      send_request(poll(0, 1, 0, 1));
      send_request(poll(0, 0, 0, 1));
      send_request(poll(0, 0, 40, 1));
      pause_sender($urandom_range(0, 2));
      send_request(poll(0, 0, 41, 1));
      send_request(poll(0, 0, 700, 1));
      send_request(poll(0, 0, 700, 1));
      send_request(poll(0, 0, 700, 1));
      finish_phase();

      // random phases, the first two with fixed edge settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_settings(7'd127, 7'd99, 10'd0, 10'd1023, 10'd1023);
            1: apply_settings(7'd1, 7'd0, 10'd1000, 10'd1000, 10'd1000);
            default: apply_settings(pick_seconds(), pick_seconds(), pick_limit(), pick_limit(),
                                    ($urandom_range(0, 3) == 0) ? TempWidth'($urandom_range(0, 1023))
                                                                : TempWidth'($urandom_range(0, 30)));
         endcase
         n = 0;
         while (n < 75) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            repeat (burst) begin
               send_request(next_poll());
               n++;
            end
            pause_sender($urandom_range(0, 5));
         end
         finish_phase();
      end

      if (board.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/ttc_pkg.sv
hdl/timed_thermostat_controller_unit.sv
tb/timed_thermostat_controller_unit_tb.sv
